FILE: src/sha_pkg.sv
package sha_pkg;

  localparam int unsigned BLOCK_WORDS  = 16;
  localparam int unsigned ROUNDS       = 64;
  localparam int unsigned DIGEST_WORDS = 8;
  localparam int unsigned QUEUE_DEPTH  = 4;

  // one word beat from the front end to the compression engine
  typedef struct packed {
    logic [31:0] word;
    logic        msg_end;  // last word of the last block of a message
  } sha_beat_t;

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

FILE: src/sha256_stream_hasher.sv
// Channel  Handshake          Payload                                       Beat moves
// -------  -----------------  --------------------------------------------  -------------------
// input    push / full        data_word_i[31:0] byte_count_i[2:0] final_item_i  message word
// result   empty / pop        digest_word_o[31:0] word_index_o[2:0] last_word_o  one digest word
//
// An input beat is taken while the word queue has room and no padding is under way; a final beat
// is followed by 3 to 18 padding words (0x80 marker, zero fill, 64-bit bit length), one per cycle
// while the queue has room, with full high throughout.
// The compression engine works through each 64-byte block in 16 loads, 64 rounds of one shared
// round unit and one chaining add, and pops no new word until that block is through.
// A word queue separates front end and engine; eight digest words follow each message,
// and the engine holds in its final add until the previous digest has been popped.
// Reset is asynchronous, active low; it loads the initial hash values, no clearing pass.
module sha256_stream_hasher #(
  parameter int unsigned QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        final_item_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  // word beats between the byte packer and the engine
  sha_pkg::sha_beat_t fq_in, fq_out;
  logic fq_push, fq_full, fq_pop, fq_empty;

  // byte packer and padding sequencer
  sha_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .final_item_i (final_item_i),
    .full_o       (full),
    .q_full_i     (fq_full),
    .q_push_o     (fq_push),
    .q_data_o     (fq_in)
  );

  sha_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_in),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .data_o  (fq_out),
    .empty_o (fq_empty)
  );

  // schedule, round unit, chaining and digest hold register
  sha_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_data_i      (fq_out),
    .q_empty_i     (fq_empty),
    .q_pop_o       (fq_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

endmodule

FILE: src/sha_front.sv
module sha_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [31:0]       data_word_i,
  input  logic [2:0]        byte_count_i,
  input  logic              final_item_i,
  output logic              full_o,
  input  logic              q_full_i,
  output logic              q_push_o,
  output sha_pkg::sha_beat_t q_data_o
);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_PAD   = 3'd1;
  localparam logic [2:0] F_ZERO  = 3'd2;
  localparam logic [2:0] F_LENHI = 3'd3;
  localparam logic [2:0] F_LENLO = 3'd4;

  localparam logic [3:0] LEN_POS = 4'd14;  // word slot of the length high half

  localparam logic [7:0] PAD_BYTE_W = sha_pkg::PAD_BYTE;

  logic [2:0]  state_q, state_d;
  logic [23:0] acc_q, acc_d;      // leftover bytes, first byte at the top
  logic [1:0]  acc_n_q, acc_n_d;
  logic [60:0] msg_q, msg_d;
  logic [3:0]  pos_q, pos_d;      // word slot within the current block

  logic [2:0]  cnt_sat;
  logic [31:0] data_m;
  logic [55:0] cat;
  logic [2:0]  total;
  logic [3:0]  pos_inc;
  logic        accept;

  assign full_o = (state_q != F_IDLE) || q_full_i;
  assign accept = push_i && !full_o;

  always_comb begin
    cnt_sat = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
    data_m  = data_word_i & ~(32'hFFFF_FFFF >> {cnt_sat, 3'b000});
    cat     = {acc_q, 32'h0} | ({data_m, 24'h0} >> {acc_n_q, 3'b000});
    total   = {1'b0, acc_n_q} + cnt_sat;
    pos_inc = pos_q + 4'd1;

    state_d  = state_q;
    acc_d    = acc_q;
    acc_n_d  = acc_n_q;
    msg_d    = msg_q;
    q_push_o = 1'b0;
    q_data_o = '{word: cat[55:24], msg_end: 1'b0};

    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          msg_d = msg_q + 61'(cnt_sat);
          if (total >= 3'd4) begin
            q_push_o = 1'b1;
            acc_d    = cat[23:0];
            acc_n_d  = 2'(total - 3'd4);
          end else begin
            acc_d   = cat[55:32];
            acc_n_d = total[1:0];
          end
          if (final_item_i) begin
            state_d = F_PAD;
          end
        end
      end
      F_PAD: begin
        // leftover bytes, then the 0x80 marker, then zeros
        q_data_o.word = {acc_q, 8'h00} | ({PAD_BYTE_W, 24'h0} >> {acc_n_q, 3'b000});
        if (!q_full_i) begin
          q_push_o = 1'b1;
          acc_d    = '0;
          acc_n_d  = '0;
          state_d  = (pos_inc == LEN_POS) ? F_LENHI : F_ZERO;
        end
      end
      F_ZERO: begin
        q_data_o.word = '0;
        if (!q_full_i) begin
          q_push_o = 1'b1;
          if (pos_inc == LEN_POS) begin
            state_d = F_LENHI;
          end
        end
      end
      F_LENHI: begin
        q_data_o.word = msg_q[60:29];
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_LENLO;
        end
      end
      F_LENLO: begin
        q_data_o = '{word: {msg_q[28:0], 3'b000}, msg_end: 1'b1};
        if (!q_full_i) begin
          q_push_o = 1'b1;
          msg_d    = '0;
          state_d  = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase

    pos_d = q_push_o ? pos_inc : pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      acc_q   <= '0;
      acc_n_q <= '0;
      msg_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      acc_n_q <= acc_n_d;
      msg_q   <= msg_d;
      pos_q   <= pos_d;
    end
  end

endmodule

FILE: src/sha_queue.sv
module sha_queue #(
  parameter int unsigned DEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sha_pkg::sha_beat_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output sha_pkg::sha_beat_t data_o,
  output logic               empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sha_pkg::sha_beat_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

FILE: src/sha_core.sv
module sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha_pkg::sha_beat_t q_data_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output logic [31:0]        digest_word_o,
  output logic [2:0]         word_index_o,
  output logic               last_word_o
);

  localparam logic [1:0] B_LOAD = 2'd0;
  localparam logic [1:0] B_RUN  = 2'd1;
  localparam logic [1:0] B_ADD  = 2'd2;

  localparam logic [5:0] LOAD_LAST  = 6'(sha_pkg::BLOCK_WORDS - 1);
  localparam logic [5:0] ROUND_LAST = 6'(sha_pkg::ROUNDS - 1);

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'h000, x[31:10]};
  endfunction

  logic [1:0]  state_q;
  logic [5:0]  cnt_q;
  logic        end_q;
  logic        dig_valid_q;
  logic [2:0]  idx_q;
  logic [31:0] h_q   [sha_pkg::DIGEST_WORDS];
  logic [31:0] s_q   [sha_pkg::DIGEST_WORDS];
  logic [31:0] dig_q [sha_pkg::DIGEST_WORDS];
  logic [31:0] w_q   [sha_pkg::BLOCK_WORDS];

  logic [31:0] t1, t2, w_new;
  logic [31:0] sum [sha_pkg::DIGEST_WORDS];
  logic        load_beat, finish_msg, out_beat;

  always_comb begin
    t1 = s_q[7] + bsig1(s_q[4]) + ((s_q[4] & s_q[5]) ^ (~s_q[4] & s_q[6]))
         + sha_pkg::ROUND_K[cnt_q] + w_q[0];
    t2 = bsig0(s_q[0]) + ((s_q[0] & s_q[1]) ^ (s_q[0] & s_q[2]) ^ (s_q[1] & s_q[2]));
    w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
    for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++) begin
      sum[i] = h_q[i] + s_q[i];
    end
  end

  assign q_pop_o    = (state_q == B_LOAD) && !q_empty_i;
  assign load_beat  = q_pop_o;
  // the digest register must be drained before the next one lands
  assign finish_msg = (state_q == B_ADD) && end_q && !dig_valid_q;
  assign out_beat   = pop_i && dig_valid_q;

  assign empty_o       = !dig_valid_q;
  assign digest_word_o = dig_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'(sha_pkg::DIGEST_WORDS - 1));

  // datapath
  always_ff @(posedge clk_i) begin
    if (load_beat) begin
      for (int i = 0; i < sha_pkg::BLOCK_WORDS - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[sha_pkg::BLOCK_WORDS-1] <= q_data_i.word;
      if (cnt_q == LOAD_LAST) begin
        for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++) begin
          s_q[i] <= h_q[i];
        end
      end
    end
    if (state_q == B_RUN) begin
      for (int i = 0; i < sha_pkg::BLOCK_WORDS - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[sha_pkg::BLOCK_WORDS-1] <= w_new;
      s_q[0] <= t1 + t2;
      s_q[1] <= s_q[0];
      s_q[2] <= s_q[1];
      s_q[3] <= s_q[2];
      s_q[4] <= s_q[3] + t1;
      s_q[5] <= s_q[4];
      s_q[6] <= s_q[5];
      s_q[7] <= s_q[6];
    end
    if (finish_msg) begin
      for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++) begin
        dig_q[i] <= sum[i];
      end
    end
  end

  // control and chaining state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_LOAD;
      cnt_q       <= '0;
      end_q       <= 1'b0;
      dig_valid_q <= 1'b0;
      idx_q       <= '0;
      for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++) begin
        h_q[i] <= sha_pkg::INIT_H[i];
      end
    end else begin
      unique case (state_q)
        B_LOAD: begin
          if (load_beat) begin
            if (cnt_q == LOAD_LAST) begin
              end_q   <= q_data_i.msg_end;
              cnt_q   <= '0;
              state_q <= B_RUN;
            end else begin
              cnt_q <= cnt_q + 6'd1;
            end
          end
        end
        B_RUN: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == ROUND_LAST) begin
            state_q <= B_ADD;
          end
        end
        B_ADD: begin
          cnt_q <= '0;
          if (!end_q) begin
            for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++) begin
              h_q[i] <= sum[i];
            end
            state_q <= B_LOAD;
          end else if (finish_msg) begin
            for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++) begin
              h_q[i] <= sha_pkg::INIT_H[i];
            end
            state_q <= B_LOAD;
          end
        end
        default: begin
          state_q <= B_LOAD;
        end
      endcase

      if (finish_msg) begin
        dig_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (out_beat) begin
        idx_q <= idx_q + 3'd1;
        if (last_word_o) begin
          dig_valid_q <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: tb/sv/sha256_stream_hasher_tb.sv
`timescale 1ns / 100ps

module sha256_stream_hasher_tb;

  // ---------------------------------------------------------------------------
  // Bench constants
  // ---------------------------------------------------------------------------
  localparam int unsigned CYCLE_LIMIT   = 200000;  // far beyond the slowest run
  localparam int unsigned SETTLE_CYCLES = 250;     // room for a stray digest beat
  localparam int unsigned PHASE_ITEMS   = 35;      // minimum random beats per idling phase
  localparam int unsigned MAX_BYTES     = 4;       // bytes carried by a full word

  // SHA-256 round constants and initial chaining words, kept locally so that a
  // mistake in the design's tables cannot hide in the prediction
  localparam logic [31:0] K_ROUND [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_START [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARKER = 8'h80;

  // well-known digests: the empty message and "abc"
  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  // rows with a typed-in digest name it here; all others go through the predictor
  typedef enum logic [1:0] {
    GOLD_NONE,
    GOLD_EMPTY,
    GOLD_ABC
  } gold_sel_e;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        fin;
    gold_sel_e   gold;
  } msg_row_t;

  localparam int unsigned N_DIRECTED = 23;

  localparam msg_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // empty message straight after reset
    '{32'h0000_0000, 3'd0, 1'b1, GOLD_EMPTY},
    // "abc" in one short final beat; the unused low byte is all ones
    '{32'h6162_63ff, 3'd3, 1'b1, GOLD_ABC},
    // byte counts above four saturate; short non-final beats pack tightly
    '{32'hffff_ffff, 3'd7, 1'b0, GOLD_NONE},
    '{32'h0000_0000, 3'd5, 1'b0, GOLD_NONE},
    '{32'h1234_5678, 3'd1, 1'b0, GOLD_NONE},
    '{32'h9abc_def0, 3'd2, 1'b0, GOLD_NONE},
    '{32'hdead_beef, 3'd6, 1'b1, GOLD_NONE},
    // 56-byte message: the length no longer fits, so padding spills a block
    '{32'hffff_ffff, 3'd4, 1'b0, GOLD_NONE},
    '{32'h0000_0000, 3'd4, 1'b0, GOLD_NONE},
    '{32'haaaa_aaaa, 3'd4, 1'b0, GOLD_NONE},
    '{32'h5555_5555, 3'd4, 1'b0, GOLD_NONE},
    '{32'hffff_ffff, 3'd4, 1'b0, GOLD_NONE},
    '{32'h0000_0001, 3'd4, 1'b0, GOLD_NONE},
    '{32'h8000_0000, 3'd4, 1'b0, GOLD_NONE},
    '{32'h0123_4567, 3'd4, 1'b0, GOLD_NONE},
    '{32'h89ab_cdef, 3'd4, 1'b0, GOLD_NONE},
    '{32'hfedc_ba98, 3'd4, 1'b0, GOLD_NONE},
    '{32'h7654_3210, 3'd4, 1'b0, GOLD_NONE},
    '{32'hffff_ffff, 3'd4, 1'b0, GOLD_NONE},
    '{32'h0000_0000, 3'd4, 1'b0, GOLD_NONE},
    '{32'ha5a5_a5a5, 3'd4, 1'b1, GOLD_NONE},
    // bytes taken, then an empty final beat closes the message
    '{32'h8000_0000, 3'd4, 1'b0, GOLD_NONE},
    '{32'hffff_ffff, 3'd0, 1'b1, GOLD_NONE}
  };

  // ---------------------------------------------------------------------------
  // DUT hook-up; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        push         = 1'b0;
  logic        full;
  logic [31:0] data_word_i  = '0;
  logic [2:0]  byte_count_i = '0;
  logic        final_item_i = 1'b0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_stream_hasher DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .final_item_i (final_item_i),
    .empty        (empty),
    .pop          (pop),
    .digest_word_o(digest_word_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  digest_beat_t digest_expect_q [$];
  digest_beat_t want_beat;

  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned phase_items    = 0;
  int unsigned send_gap_pct   = 6;   // chance of an idle cycle before a beat
  int unsigned recv_stall_pct = 47;  // chance of pop low in a cycle

  // hashing state of the predictor
  logic [31:0] pred_chain [8];
  logic [7:0]  pred_block [64];
  int unsigned pred_fill;
  logic [60:0] pred_msg_bytes;       // wraps modulo 2^61 like the design's counter

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rotr32(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void pred_restart();
    int i;
    for (i = 0; i < 8; i++) pred_chain[i] = H_START[i];
    pred_fill      = 0;
    pred_msg_bytes = '0;
  endfunction

  // 64 rounds over the 64 buffered bytes, folded into the chaining words
  function automatic void sha_compress_block();
    logic [31:0] w [64];
    logic [31:0] s [8];
    logic [31:0] t1, t2, x, y;
    int i;
    for (i = 0; i < 16; i++)
      w[i] = {pred_block[4*i], pred_block[4*i+1], pred_block[4*i+2], pred_block[4*i+3]};
    for (i = 16; i < 64; i++) begin
      x    = w[i-15];
      y    = w[i-2];
      w[i] = (rotr32(y, 17) ^ rotr32(y, 19) ^ (y >> 10)) + w[i-7]
           + (rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3)) + w[i-16];
    end
    for (i = 0; i < 8; i++) s[i] = pred_chain[i];
    for (i = 0; i < 64; i++) begin
      t1 = s[7] + (rotr32(s[4], 6) ^ rotr32(s[4], 11) ^ rotr32(s[4], 25))
         + ((s[4] & s[5]) ^ (~s[4] & s[6])) + K_ROUND[i] + w[i];
      t2 = (rotr32(s[0], 2) ^ rotr32(s[0], 13) ^ rotr32(s[0], 22))
         + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
      s[7] = s[6];
      s[6] = s[5];
      s[5] = s[4];
      s[4] = s[3] + t1;
      s[3] = s[2];
      s[2] = s[1];
      s[1] = s[0];
      s[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) pred_chain[i] = pred_chain[i] + s[i];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    pred_block[pred_fill] = b;
    pred_fill++;
    if (pred_fill == 64) begin
      sha_compress_block();
      pred_fill = 0;
    end
  endfunction

  // Takes one accepted beat; on a final beat pads, returns the digest and
  // starts over from the initial chaining words.
  function automatic bit hash_take_item(input logic [31:0] word, input logic [2:0] nbytes,
                                        input logic fin, output logic [31:0] digest [8]);
    int unsigned n;
    logic [63:0] bit_len;
    int i;
    n = (nbytes > MAX_BYTES) ? MAX_BYTES : nbytes;
    for (i = 0; i < n; i++) begin
      absorb_byte(word[31-8*i -: 8]);
      pred_msg_bytes = pred_msg_bytes + 61'd1;
    end
    if (!fin) return 1'b0;
    bit_len = {pred_msg_bytes, 3'b000};
    absorb_byte(PAD_MARKER);
    if (pred_fill > 56) begin
      while (pred_fill != 0) absorb_byte(8'h00);
    end
    while (pred_fill < 56) absorb_byte(8'h00);
    for (i = 0; i < 8; i++) absorb_byte(bit_len[63-8*i -: 8]);
    for (i = 0; i < 8; i++) digest[i] = pred_chain[i];
    pred_restart();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: random gaps, then hold the beat until full is seen low at an edge.
  // The predictor is stepped at the accepting edge; typed-in digests, where
  // the row has one, take the place of the predicted words.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [31:0] word, input logic [2:0] nbytes,
                           input logic fin, input gold_sel_e gold);
    logic [31:0] digest [8];
    logic [255:0] typed;
    bit done;
    int i;
    while ($urandom_range(99) < send_gap_pct) begin
      push         <= 1'b0;
      data_word_i  <= $urandom;          // junk on the bus while idle
      byte_count_i <= 3'($urandom);
      final_item_i <= 1'($urandom);
      @(posedge clk_i);
    end
    push         <= 1'b1;
    data_word_i  <= word;
    byte_count_i <= nbytes;
    final_item_i <= fin;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    phase_items++;
    done = hash_take_item(word, nbytes, fin, digest);
    if (done) begin
      typed = (gold == GOLD_EMPTY) ? EMPTY_DIGEST : ABC_DIGEST;
      for (i = 0; i < 8; i++) begin
        if (gold != GOLD_NONE) digest[i] = typed[255-32*i -: 32];
        digest_expect_q.push_back(digest_beat_t'{digest[i], 3'(i), (i == 7)});
      end
    end
  endtask

  // One message of random content: mostly full words, now and then short or
  // over-long byte counts, lengths spread across the block boundaries.
  task automatic send_random_message();
    int unsigned n_words;
    int unsigned roll;
    logic [2:0] nbytes;
    int i;
    roll = $urandom_range(99);
    if (roll < 10)      n_words = 0;
    else if (roll < 85) n_words = $urandom_range(20, 1);
    else                n_words = $urandom_range(40, 21);
    for (i = 0; i < n_words; i++) begin
      nbytes = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'(MAX_BYTES);
      send_beat($urandom, nbytes, 1'b0, GOLD_NONE);
    end
    send_beat($urandom, 3'($urandom_range(7)), 1'b1, GOLD_NONE);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: pop stalls at random, every popped digest beat is checked
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (digest_expect_q.size() == 0) begin
        $display("%0t: digest beat with none expected: word %h index %0d last %b",
                 $time, digest_word_o, word_index_o, last_word_o);
        fail_count++;
      end else begin
        want_beat = digest_expect_q.pop_front();
        if (digest_word_o !== want_beat.word) begin
          $display("%0t: digest_word mismatch: expected %h, got %h",
                   $time, want_beat.word, digest_word_o);
          fail_count++;
        end
        if (word_index_o !== want_beat.index) begin
          $display("%0t: word_index mismatch: expected %0d, got %0d",
                   $time, want_beat.index, word_index_o);
          fail_count++;
        end
        if (last_word_o !== want_beat.last) begin
          $display("%0t: last_word mismatch: expected %b, got %b",
                   $time, want_beat.last, last_word_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** sha256_stream_hasher: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned r;
    int unsigned phase;
    pred_restart();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table, under the first idling mix
    for (r = 0; r < N_DIRECTED; r++)
      send_beat(DIRECTED_ROWS[r].word, DIRECTED_ROWS[r].nbytes,
                DIRECTED_ROWS[r].fin, DIRECTED_ROWS[r].gold);

    // random messages: slow receiver, then slow sender, then flat out
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct   = 6;
          recv_stall_pct = 47;
        end
        1: begin
          send_gap_pct   = 47;
          recv_stall_pct = 6;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) send_random_message();
    end
    push <= 1'b0;

    // drain, then leave time for anything spurious to show up
    while (digest_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("** sha256_stream_hasher: PASSED **");
    end else begin
      $display("** sha256_stream_hasher: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/sha_pkg.sv
src/sha_front.sv
src/sha_queue.sv
src/sha_core.sv
src/sha256_stream_hasher.sv
tb/sv/sha256_stream_hasher_tb.sv
